[src/pt32_pkg.sv]
package pt32_pkg;

  localparam int unsigned NW = 32;                 // candidate width
  localparam int unsigned DW = 11;                 // trial divisor width
  localparam logic [NW-1:0] SmallLimit = 32'd1373653;
  localparam logic [NW-1:0] MidLimit   = 32'd9080191;

  // controller states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_W3   = 10'b00_0000_0010,
    ST_TCHK = 10'b00_0000_0100,
    ST_WD1  = 10'b00_0000_1000,
    ST_WD2  = 10'b00_0001_0000,
    ST_TZ   = 10'b00_0010_0000,
    ST_PSQ  = 10'b00_0100_0000,
    ST_PMUL = 10'b00_1000_0000,
    ST_LOOP = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  // request to the serial modular multiplier: (a * b) mod m, a < m
  typedef struct packed {
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    logic [NW-1:0] m;
  } mm_req_t;

  // witness base by range and index
  function automatic logic [NW-1:0] base_of(input logic mid, input logic [1:0] idx);
    logic [NW-1:0] b;
    b = 32'd2;
    if (mid) begin
      b = (idx == 2'd0) ? 32'd31 : 32'd73;
    end else begin
      case (idx)
        2'd0:    b = 32'd2;
        2'd1:    b = 32'd7;
        default: b = 32'd61;
      endcase
    end
    return b;
  endfunction

endpackage

[src/pt32_if.sv]
interface pt32_cand_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface pt32_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

[src/prime_test_32.sv]
// Numbers below 2 and even numbers are decided without the multiplier; other multiples
// of 3 are found by one reduction mod 3; candidates below 1373653 are tested by trial
// division with divisor pairs 6k-1 and 6k+1, larger ones by Miller-Rabin over the
// witness bases, each step a modular multiply.
// Throughput: one item at a time, set by the single bit-serial multiplier.
// Reset clears the controller and the output valid; data registers are not reset.
module prime_test_32 (
  input  logic      clk_i,
  input  logic      rst_ni,
  pt32_cand_if.sink cand_i,
  pt32_res_if.source res_o
);
  import pt32_pkg::*;

  state_e        state_q, state_d;
  logic [NW-1:0] n_q, n_d, odd_q, odd_d, acc_q, acc_d;
  logic [DW-1:0] d1_q, d1_d;
  logic [4:0]    twos_q, twos_d, bit_q, bit_d;
  logic [1:0]    bidx_q, bidx_d;
  logic          res_q, res_d, ov_q, ov_d, op_q, op_d;
  logic          start_q, start_d;
  mm_req_t       req_q, req_d;
  logic          mm_done;
  logic [NW-1:0] mm_res, base, nm1;
  logic [2*DW-1:0] dsq;
  logic          mid, last_base, adv;

  pt32_mulmod u_mm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .req_i   (req_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  assign mid       = n_q < MidLimit;
  assign base      = base_of(mid, bidx_q);
  assign last_base = mid ? (bidx_q == 2'd1) : (bidx_q == 2'd2);
  assign nm1       = n_q - 32'd1;
  assign dsq       = d1_q * d1_q;
  assign adv       = (state_q == ST_PMUL) || !odd_q[bit_q];

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d = n_q; odd_d = odd_q; acc_d = acc_q; d1_d = d1_q;
    twos_d = twos_q; bit_d = bit_q; bidx_d = bidx_q;
    res_d = res_q; start_d = 1'b0; req_d = req_q;
    case (state_q)
      ST_IDLE: begin
        if (cand_i.valid) begin
          n_d = cand_i.candidate;
          if (cand_i.candidate < 32'd2) begin
            res_d = 1'b0; state_d = ST_FIN;
          end else if (!cand_i.candidate[0]) begin
            res_d = (cand_i.candidate == 32'd2); state_d = ST_FIN;
          end else begin
            req_d = '{a: 32'd1, b: cand_i.candidate, m: 32'd3};
            start_d = 1'b1; state_d = ST_W3;
          end
        end
      end
      ST_W3: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            res_d = (n_q == 32'd3); state_d = ST_FIN;
          end else if (n_q < SmallLimit) begin
            d1_d = DW'(5); state_d = ST_TCHK;
          end else begin
            odd_d = {1'b0, nm1[NW-1:1]}; twos_d = 5'd1; bidx_d = '0;
            state_d = ST_TZ;
          end
        end
      end
      ST_TCHK: begin
        if ({10'd0, dsq} <= n_q) begin
          req_d = '{a: 32'd1, b: n_q, m: {21'd0, d1_q}};
          start_d = 1'b1; state_d = ST_WD1;
        end else begin
          res_d = 1'b1; state_d = ST_FIN;
        end
      end
      ST_WD1: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            res_d = 1'b0; state_d = ST_FIN;
          end else begin
            req_d = '{a: 32'd1, b: n_q, m: {21'd0, d1_q} + 32'd2};
            start_d = 1'b1; state_d = ST_WD2;
          end
        end
      end
      ST_WD2: begin
        if (mm_done) begin
          if (mm_res == '0) begin
            res_d = 1'b0; state_d = ST_FIN;
          end else begin
            d1_d = d1_q + DW'(6); state_d = ST_TCHK;
          end
        end
      end
      // strip factors of two from n-1
      ST_TZ: begin
        if (!odd_q[0] && odd_q != '0) begin
          odd_d = {1'b0, odd_q[NW-1:1]}; twos_d = twos_q + 5'd1;
        end else begin
          acc_d = 32'd1; bit_d = 5'd31;
          req_d = '{a: 32'd1, b: 32'd1, m: n_q};
          start_d = 1'b1; state_d = ST_PSQ;
        end
      end
      // left-to-right exponentiation: square, then multiply on a set bit
      ST_PSQ, ST_PMUL: begin
        if (mm_done) begin
          acc_d = mm_res;
          if (!adv) begin
            req_d = '{a: mm_res, b: base, m: n_q};
            start_d = 1'b1; state_d = ST_PMUL;
          end else if (bit_q == 5'd0) begin
            req_d = '{a: mm_res, b: mm_res, m: n_q};
            bit_d = twos_q; start_d = 1'b1; state_d = ST_LOOP;
          end else begin
            bit_d = bit_q - 5'd1;
            req_d = '{a: mm_res, b: mm_res, m: n_q};
            start_d = 1'b1; state_d = ST_PSQ;
          end
        end
      end
      // repeated squaring; acc holds the previous value, bit counts down
      ST_LOOP: begin
        if (mm_done) begin
          acc_d = mm_res;
          if (mm_res == 32'd1 && acc_q != 32'd1 && acc_q != nm1) begin
            res_d = 1'b0; state_d = ST_FIN;
          end else if (bit_q == 5'd1) begin
            if (mm_res != 32'd1) begin
              res_d = 1'b0; state_d = ST_FIN;
            end else if (last_base) begin
              res_d = 1'b1; state_d = ST_FIN;
            end else begin
              bidx_d = bidx_q + 2'd1;
              odd_d = {1'b0, nm1[NW-1:1]}; twos_d = 5'd1;
              state_d = ST_TZ;
            end
          end else begin
            bit_d = bit_q - 5'd1;
            req_d = '{a: mm_res, b: mm_res, m: n_q};
            start_d = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!ov_q || res_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    ov_d = ov_q; op_d = op_q;
    if (ov_q && res_o.ready) ov_d = 1'b0;
    if (state_q == ST_FIN && (!ov_q || res_o.ready)) begin
      ov_d = 1'b1; op_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; odd_q <= odd_d; acc_q <= acc_d; d1_q <= d1_d;
    twos_q <= twos_d; bit_q <= bit_d; bidx_q <= bidx_d;
    res_q <= res_d; req_q <= req_d; op_q <= op_d;
  end

  assign cand_i.ready = (state_q == ST_IDLE);
  assign res_o.valid  = ov_q;
  assign res_o.is_prime = op_q;
endmodule

[src/pt32_mulmod.sv]
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
module pt32_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pt32_pkg::mm_req_t req_i,
  output logic              done_o,
  output logic [31:0]       res_o
);
  import pt32_pkg::*;

  logic [NW-1:0] acc_q, acc_d, a_q, m_q, b_q;
  logic [5:0]    cnt_q;
  logic          done_q;
  logic [NW+2:0] t, t1, t2;

  // double, add, reduce (value stays below 3m)
  always_comb begin
    t  = {2'b00, acc_q, 1'b0} + (b_q[NW-1] ? {3'b000, a_q} : '0);
    t1 = t - {3'b000, m_q};
    t2 = t - {2'b00, m_q, 1'b0};
    if (!t2[NW+2])      acc_d = t2[NW-1:0];
    else if (!t1[NW+2]) acc_d = t1[NW-1:0];
    else                acc_d = t[NW-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (start_i)            cnt_q <= 6'(NW);
      else if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      m_q   <= req_i.m;
    end else if (cnt_q != 6'd0) begin
      acc_q <= acc_d;
      b_q   <= {b_q[NW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule
